/* hw/rtl/labeled_blob_centroid_stats_top_assert.svh */
// Assertion macros shared by the blob centroid statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LABELED_BLOB_CENTROID_STATS_TOP_ASSERT_SVH
`define LABELED_BLOB_CENTROID_STATS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/bcs_pkg.sv */
// Package of the blob centroid statistics block: constants, payload types,
// controller states and the command and status structs. No dependencies.
`default_nettype none
package bcs_pkg;
	localparam int unsigned MAX_DROPLETS = 64;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned DC_W = 7;
	localparam int unsigned MAX_COLUMNS = 1024;
	localparam int unsigned MAX_ROWS = 1024;
	localparam int unsigned POS_W = 10;
	localparam int unsigned WIDTH_W = 11;
	localparam int unsigned MISS_LIMIT = 10;
	localparam int unsigned CEN_W = 19;
	localparam int unsigned STAT_W = 153;
	localparam logic REG_IMAGE_WIDTH = 1'b0;

	typedef struct packed {
		logic signed [15:0] intensity;
		logic [20:0] label;
		logic end_of_frame;
	} pix_t;

	typedef struct packed {
		logic [20:0] droplet_label;
		logic [20:0] pixel_count;
		logic signed [35:0] intensity_sum;
		logic [18:0] x_centroid;
		logic [18:0] y_centroid;
		logic zero_sum_flag;
		logic [3:0] error_count;
		logic overflow_flag;
		logic last_result;
	} res_t;

	typedef struct packed {
		logic [20:0] cnt;
		logic [35:0] sum;
		logic [47:0] xm;
		logic [47:0] ym;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_SRCH_RD, ST_SRCH_CMP, ST_ACC_RD, ST_ACC_WR,
		ST_DMP_RD, ST_DMP_CAP, ST_DIVX_GO, ST_DIV_X, ST_DIV_Y, ST_EMIT, ST_CLEAR
	} state_t;

	typedef struct packed {
		logic accept;
		logic open_slot;
		logic miss;
		logic use_cur;
		logic srch_init;
		logic srch_rd;
		logic srch_hit;
		logic srch_next;
		logic acc_rd;
		logic acc_wr;
		logic dump_init;
		logic dump_rd;
		logic dump_cap;
		logic div_start;
		logic div_sel_y;
		logic cap_x;
		logic cap_y;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic is_new;
		logic is_cur;
		logic full;
		logic srch_end;
		logic hit;
		logic abort_nx;
		logic eof;
		logic dump_end;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

/* hw/rtl/labeled_blob_centroid_stats_top.sv */
// Top level of the blob centroid statistics block with its APB register.
// Depends on bcs_pkg, bcs_ctrl and bcs_dp.
`default_nettype none
// A pixel is taken when start is high and busy is low. A background pixel is
// dropped after the decision; a pixel that matches the last used droplet or
// opens a new one goes on to update its statistics; any other label scans the
// label list, one slot read and compare at a time, on the single read port of
// the label memory. On the pixel that ends the frame, one result per droplet
// follows, each set by two passes of the 19-step centroid divider. Each result
// is shown for one cycle with result_valid high; the receiver cannot stall it.
module labeled_blob_centroid_stats_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire bcs_pkg::pix_t        pixel,
	output logic                      result_valid,
	output bcs_pkg::res_t             result,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	logic [bcs_pkg::WIDTH_W-1:0] width_q;
	bcs_pkg::cmd_t cmd;
	bcs_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= bcs_pkg::WIDTH_W'(bcs_pkg::MAX_COLUMNS);
		end else if (psel && penable && pwrite && paddr[2] == bcs_pkg::REG_IMAGE_WIDTH) begin
			width_q <= pwdata[bcs_pkg::WIDTH_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bcs_pkg::REG_IMAGE_WIDTH) ? {21'b0, width_q} : '0;

	bcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	bcs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .cfg_width(width_q), .cmd(cmd),
		.sts(sts), .result_valid(result_valid), .result(result)
	);
endmodule
`default_nettype wire

/* hw/rtl/bcs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module bcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/bcs_div.sv */
// Sequential centroid divider: floor(256 * (moment + sum) / sum), clamped.
// Depends on bcs_pkg.
`default_nettype none
module bcs_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [47:0]               mom,
	input  wire logic [35:0]               sum,
	output logic                           done,
	output logic [bcs_pkg::CEN_W-1:0]      quo
);
	typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_RUN} dv_t;

	dv_t phase_q;
	logic [56:0] r_q, d_q;
	logic [35:0] us_q;
	logic zero_q, done_q;
	logic [bcs_pkg::CEN_W-1:0] q_q;
	logic [4:0] cnt_q;
	logic [48:0] num;
	logic [56:0] n57, un;
	logic [35:0] us;
	logic [56:0] lim;

	assign num = {mom[47], mom} + {{13{sum[35]}}, sum};
	assign n57 = {num, 8'b0};
	assign un = num[48] ? (57'd0 - n57) : n57;
	assign us = sum[35] ? (36'd0 - sum) : sum;
	assign lim = {2'b0, us_q, 19'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DV_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				DV_IDLE: begin
					if (start) begin
						phase_q <= DV_PREP;
					end
				end
				DV_PREP: begin
					if (zero_q || r_q >= lim) begin
						done_q <= 1'b1;
						phase_q <= DV_IDLE;
					end else begin
						phase_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (cnt_q == 5'd1) begin
						done_q <= 1'b1;
						phase_q <= DV_IDLE;
					end
				end
				default: phase_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			DV_IDLE: begin
				r_q <= un;
				us_q <= us;
				zero_q <= (num == '0) || (num[48] != sum[35]);
			end
			DV_PREP: begin
				d_q <= {3'b0, us_q, 18'b0};
				cnt_q <= 5'(bcs_pkg::CEN_W);
				if (zero_q) begin
					q_q <= '0;
				end else if (r_q >= lim) begin
					q_q <= '1;
				end else begin
					q_q <= '0;
				end
			end
			DV_RUN: begin
				if (r_q >= d_q) begin
					r_q <= r_q - d_q;
				end
				q_q <= {q_q[bcs_pkg::CEN_W-2:0], r_q >= d_q};
				d_q <= d_q >> 1;
				cnt_q <= cnt_q - 5'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo = q_q;
endmodule
`default_nettype wire

/* hw/rtl/bcs_dp.sv */
// Datapath: pixel position, label list, per-slot statistics, search and dump.
// Depends on bcs_pkg, bcs_ram, bcs_div and the assertion macro header.
`default_nettype none
`include "labeled_blob_centroid_stats_top_assert.svh"
module bcs_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bcs_pkg::pix_t                 pixel,
	input  wire logic [bcs_pkg::WIDTH_W-1:0]   cfg_width,
	input  wire bcs_pkg::cmd_t                 cmd,
	output bcs_pkg::sts_t                      sts,
	output logic                               result_valid,
	output bcs_pkg::res_t                      result
);
	logic signed [15:0] int_q;
	logic [20:0] lab_q;
	logic eof_q;
	logic [bcs_pkg::POS_W-1:0] col_q, row_q, xcol_q, yrow_q;
	logic [bcs_pkg::DC_W-1:0] dc_q, idx_q, k_q;
	logic [bcs_pkg::SLOT_W-1:0] cur_q, slot_q;
	logic [20:0] cur_lab_q, last_lab_q;
	logic [3:0] miss_q;
	logic ovf_q;
	logic [bcs_pkg::MAX_DROPLETS-1:0] vld_q;
	logic rd_vld_q;
	logic [20:0] d_lab_q;
	bcs_pkg::stat_t d_st_q;
	logic [bcs_pkg::CEN_W-1:0] qx_q;
	bcs_pkg::res_t res_q;
	logic res_valid_q;

	logic [bcs_pkg::WIDTH_W-1:0] w_eff, col_inc, row_inc;
	logic [20:0] lab_rdata;
	logic [bcs_pkg::STAT_W-1:0] st_rdata;
	bcs_pkg::stat_t st_old, st_new;
	logic signed [26:0] xp, yp;
	logic [bcs_pkg::SLOT_W-1:0] lab_raddr, st_raddr;
	logic lab_we;
	logic do_open;
	logic div_done;
	logic [bcs_pkg::CEN_W-1:0] div_q;

	assign w_eff = (cfg_width == '0 || cfg_width > bcs_pkg::WIDTH_W'(bcs_pkg::MAX_COLUMNS))
		? bcs_pkg::WIDTH_W'(bcs_pkg::MAX_COLUMNS) : cfg_width;
	assign col_inc = {1'b0, col_q} + 11'd1;
	assign row_inc = {1'b0, row_q} + 11'd1;

	assign do_open = (cmd.open_slot || cmd.miss) && !sts.full;
	assign lab_we = do_open;
	assign lab_raddr = cmd.dump_rd ? k_q[bcs_pkg::SLOT_W-1:0] : idx_q[bcs_pkg::SLOT_W-1:0];
	assign st_raddr = cmd.dump_rd ? k_q[bcs_pkg::SLOT_W-1:0] : slot_q;

	bcs_ram #(.WIDTH(21), .DEPTH(bcs_pkg::MAX_DROPLETS)) u_lab_ram (
		.clk(clk), .we(lab_we), .waddr(dc_q[bcs_pkg::SLOT_W-1:0]), .wdata(lab_q),
		.raddr(lab_raddr), .rdata(lab_rdata)
	);

	bcs_ram #(.WIDTH(bcs_pkg::STAT_W), .DEPTH(bcs_pkg::MAX_DROPLETS)) u_stat_ram (
		.clk(clk), .we(cmd.acc_wr), .waddr(slot_q), .wdata(st_new),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	assign st_old = rd_vld_q ? bcs_pkg::stat_t'(st_rdata) : '0;
	assign xp = int_q * $signed({1'b0, xcol_q});
	assign yp = int_q * $signed({1'b0, yrow_q});

	always_comb begin
		st_new.cnt = st_old.cnt + 21'd1;
		st_new.sum = st_old.sum + {{20{int_q[15]}}, int_q};
		st_new.xm = st_old.xm + {{21{xp[26]}}, xp};
		st_new.ym = st_old.ym + {{21{yp[26]}}, yp};
	end

	bcs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.mom(cmd.div_sel_y ? d_st_q.ym : d_st_q.xm), .sum(d_st_q.sum),
		.done(div_done), .quo(div_q)
	);

	always_comb begin
		sts.skip = (lab_q == '0) || (miss_q > 4'(bcs_pkg::MISS_LIMIT));
		sts.is_new = (dc_q == '0) || (lab_q > last_lab_q);
		sts.is_cur = ({1'b0, cur_q} < dc_q) && (cur_lab_q == lab_q);
		sts.full = dc_q >= bcs_pkg::DC_W'(bcs_pkg::MAX_DROPLETS);
		sts.srch_end = idx_q == dc_q;
		sts.hit = lab_rdata == lab_q;
		sts.abort_nx = miss_q >= 4'(bcs_pkg::MISS_LIMIT);
		sts.eof = eof_q;
		sts.dump_end = k_q == dc_q;
		sts.div_done = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			dc_q <= '0;
			cur_q <= '0;
			miss_q <= '0;
			ovf_q <= 1'b0;
			vld_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
			if (cmd.accept) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= 11'(bcs_pkg::MAX_ROWS)) ? '0 : row_inc[9:0];
				end else begin
					col_q <= col_inc[9:0];
				end
			end
			if (cmd.miss) begin
				miss_q <= miss_q + 4'd1;
			end
			if ((cmd.open_slot || cmd.miss) && sts.full) begin
				ovf_q <= 1'b1;
			end
			if (do_open) begin
				dc_q <= dc_q + 7'd1;
				cur_q <= dc_q[bcs_pkg::SLOT_W-1:0];
			end
			if (cmd.srch_hit) begin
				cur_q <= idx_q[bcs_pkg::SLOT_W-1:0];
			end
			if (cmd.acc_wr) begin
				vld_q[slot_q] <= 1'b1;
			end
			if (cmd.clear) begin
				col_q <= '0;
				row_q <= '0;
				dc_q <= '0;
				cur_q <= '0;
				miss_q <= '0;
				ovf_q <= 1'b0;
				vld_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			int_q <= pixel.intensity;
			lab_q <= pixel.label;
			eof_q <= pixel.end_of_frame;
			xcol_q <= col_q;
			yrow_q <= row_q;
		end
		if (do_open) begin
			slot_q <= dc_q[bcs_pkg::SLOT_W-1:0];
			cur_lab_q <= lab_q;
			last_lab_q <= lab_q;
		end
		if (cmd.use_cur) begin
			slot_q <= cur_q;
		end
		if (cmd.srch_init) begin
			idx_q <= '0;
		end
		if (cmd.srch_next) begin
			idx_q <= idx_q + 7'd1;
		end
		if (cmd.srch_hit) begin
			slot_q <= idx_q[bcs_pkg::SLOT_W-1:0];
			cur_lab_q <= lab_q;
		end
		if (cmd.acc_rd || cmd.dump_rd) begin
			rd_vld_q <= vld_q[st_raddr];
		end
		if (cmd.dump_init) begin
			k_q <= '0;
		end
		if (cmd.dump_cap) begin
			d_lab_q <= lab_rdata;
			d_st_q <= st_old;
		end
		if (cmd.cap_x) begin
			qx_q <= div_q;
		end
		if (cmd.cap_y) begin
			res_q.droplet_label <= d_lab_q;
			res_q.pixel_count <= d_st_q.cnt;
			res_q.intensity_sum <= d_st_q.sum;
			res_q.zero_sum_flag <= d_st_q.sum == '0;
			res_q.x_centroid <= (d_st_q.sum == '0) ? '0 : qx_q;
			res_q.y_centroid <= (d_st_q.sum == '0) ? '0 : div_q;
			res_q.error_count <= miss_q;
			res_q.overflow_flag <= ovf_q;
			res_q.last_result <= (k_q + 7'd1) == dc_q;
		end
		if (cmd.emit) begin
			k_q <= k_q + 7'd1;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`BCS_ASSERT_NXT(a_clear_resets, clk, arst_n, cmd.clear, (dc_q == '0) && (miss_q == '0) && !ovf_q)
	`BCS_ASSERT_IMP(a_acc_slot_open, clk, arst_n, cmd.acc_wr, ({1'b0, slot_q} < dc_q))
	`BCS_ASSERT_IMP(a_emit_in_range, clk, arst_n, cmd.emit, (k_q < dc_q))
endmodule
`default_nettype wire

/* hw/rtl/bcs_ctrl.sv */
// Controller state machine: sequences lookup, accumulation and the dump.
// Depends on bcs_pkg.
`default_nettype none
module bcs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire bcs_pkg::sts_t  sts,
	output logic                busy,
	output bcs_pkg::cmd_t       cmd
);
	bcs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		bcs_pkg::state_t fin;
		fin = sts.eof ? bcs_pkg::ST_DMP_RD : bcs_pkg::ST_IDLE;
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			bcs_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = bcs_pkg::ST_DECIDE;
				end
			end
			bcs_pkg::ST_DECIDE: begin
				priority if (sts.skip) begin
					cmd.dump_init = sts.eof;
					state_d = fin;
				end else if (sts.is_new) begin
					cmd.open_slot = 1'b1;
					cmd.dump_init = sts.full && sts.eof;
					state_d = sts.full ? fin : bcs_pkg::ST_ACC_RD;
				end else if (sts.is_cur) begin
					cmd.use_cur = 1'b1;
					state_d = bcs_pkg::ST_ACC_RD;
				end else begin
					cmd.srch_init = 1'b1;
					state_d = bcs_pkg::ST_SRCH_RD;
				end
			end
			bcs_pkg::ST_SRCH_RD: begin
				if (sts.srch_end) begin
					cmd.miss = 1'b1;
					cmd.dump_init = (sts.full || sts.abort_nx) && sts.eof;
					state_d = (sts.full || sts.abort_nx) ? fin : bcs_pkg::ST_ACC_RD;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d = bcs_pkg::ST_SRCH_CMP;
				end
			end
			bcs_pkg::ST_SRCH_CMP: begin
				if (sts.hit) begin
					cmd.srch_hit = 1'b1;
					state_d = bcs_pkg::ST_ACC_RD;
				end else begin
					cmd.srch_next = 1'b1;
					state_d = bcs_pkg::ST_SRCH_RD;
				end
			end
			bcs_pkg::ST_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d = bcs_pkg::ST_ACC_WR;
			end
			bcs_pkg::ST_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				cmd.dump_init = sts.eof;
				state_d = fin;
			end
			bcs_pkg::ST_DMP_RD: begin
				if (sts.dump_end) begin
					state_d = bcs_pkg::ST_CLEAR;
				end else begin
					cmd.dump_rd = 1'b1;
					state_d = bcs_pkg::ST_DMP_CAP;
				end
			end
			bcs_pkg::ST_DMP_CAP: begin
				cmd.dump_cap = 1'b1;
				state_d = bcs_pkg::ST_DIVX_GO;
			end
			bcs_pkg::ST_DIVX_GO: begin
				cmd.div_start = 1'b1;
				state_d = bcs_pkg::ST_DIV_X;
			end
			bcs_pkg::ST_DIV_X: begin
				if (sts.div_done) begin
					cmd.cap_x = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d = bcs_pkg::ST_DIV_Y;
				end
			end
			bcs_pkg::ST_DIV_Y: begin
				if (sts.div_done) begin
					cmd.cap_y = 1'b1;
					state_d = bcs_pkg::ST_EMIT;
				end
			end
			bcs_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = bcs_pkg::ST_DMP_RD;
			end
			bcs_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d = bcs_pkg::ST_IDLE;
			end
			default: state_d = bcs_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != bcs_pkg::ST_IDLE;
endmodule
`default_nettype wire
